/* rtl/ipu_pkg.sv */
// Shared types, constants and helper functions of the integer pixel upscaler.
// No dependencies; every other file of the block imports this package.
package ipu_pkg;

  // Frame store geometry
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int MaxScale  = 16;

  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int AddrW   = RowW + ColW;
  localparam int RepW    = $clog2(MaxScale);
  localparam int ScaleW  = 5;
  localparam int SizeW   = 9;
  localparam int ChanW   = 8;
  localparam int PixW    = 3 * ChanW;
  localparam int PosW    = 12;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = SizeW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegScaleX      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegScaleY      = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegFrameHeight = CfgIdxW'(3);

  // Input mode codes
  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeFetch = 1'b1;

  // Queue depth between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // One command from the front to the back
  typedef struct packed {
    logic             is_load;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pix;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic             frame_end;
  } ipu_cmd_t;

  // Map a scale of 0 to 1 and clip above the maximum
  function automatic logic [ScaleW-1:0] clamp_scale(input logic [ScaleW-1:0] v);
    logic [ScaleW-1:0] r;
    if (v == '0) r = ScaleW'(1);
    else if (v > ScaleW'(MaxScale)) r = ScaleW'(MaxScale);
    else r = v;
    return r;
  endfunction

  // Map a size of 0 to 1 and clip above the given maximum
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                   input logic [SizeW-1:0] hi);
    logic [SizeW-1:0] r;
    if (v == '0) r = SizeW'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

/* rtl/ipu_if.sv */
// Valid/ready channel interfaces for pixel input and scaled pixel output.
// Depends on ipu_pkg for field widths.
interface ipu_in_if;
  import ipu_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ChanW-1:0] in_red;
  logic [ChanW-1:0] in_green;
  logic [ChanW-1:0] in_blue;

  modport source (output valid, mode, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface ipu_out_if;
  import ipu_pkg::*;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [PosW-1:0]  out_row;
  logic [PosW-1:0]  out_col;
  logic             frame_end;

  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                  frame_end, output ready);
endinterface

/* rtl/integer_pixel_upscaler_vflip.sv */
// Integer nearest-neighbor upscaler with vertical flip: front, queue, back.
// A fetch goes through the queue and the registered store read before the
// output valid rises. Throughput: one transaction per cycle while the queue
// has room and the output is taken, set by the single frame store port.
// Reset clears configuration to defaults and all positions; the frame store
// contents stay undefined until loaded. Depends on ipu_pkg and ipu_if.
module integer_pixel_upscaler_vflip (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ipu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ipu_pkg::CfgW-1:0]     cfg_data_i,
  ipu_in_if.sink                       in_ch,
  ipu_out_if.source                    out_ch
);
  import ipu_pkg::*;

  ipu_cmd_t        push_cmd, head_cmd;
  logic            push, full, pop, empty;
  logic [PixW-1:0] pix_in, pix_out;

  assign pix_in = {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

  ipu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .mode_i     (in_ch.mode),
    .pix_i      (pix_in),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  ipu_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_cmd),
    .empty_o (empty)
  );

  ipu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_pix_o       (pix_out),
    .out_row_o       (out_ch.out_row),
    .out_col_o       (out_ch.out_col),
    .out_frame_end_o (out_ch.frame_end)
  );

  // Split the stored pixel into its color channels
  assign out_ch.out_red   = pix_out[PixW-1 -: ChanW];
  assign out_ch.out_green = pix_out[ChanW +: ChanW];
  assign out_ch.out_blue  = pix_out[ChanW-1:0];

endmodule

/* rtl/ipu_front.sv */
// Front part: configuration registers, load and read position tracking,
// and turning each transaction into a command for the queue. Uses ipu_pkg.
module ipu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipu_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [ipu_pkg::PixW-1:0]      pix_i,
  output logic                          push_o,
  output ipu_pkg::ipu_cmd_t             cmd_o,
  input  logic                          full_i
);
  import ipu_pkg::*;

  logic [ScaleW-1:0] scale_x_q, scale_y_q;
  logic [SizeW-1:0]  width_q, height_q;
  logic [ScaleW-1:0] sx, sy;
  logic [SizeW-1:0]  w, h;

  logic [RowW-1:0] load_row_q, load_row_d;
  logic [ColW-1:0] load_col_q, load_col_d;
  logic [RowW-1:0] src_row_q, src_row_d;
  logic [ColW-1:0] src_col_q, src_col_d;
  logic [RepW-1:0] rep_row_q, rep_row_d;
  logic [RepW-1:0] rep_col_q, rep_col_d;
  logic [PosW-1:0] scaled_row_q, scaled_row_d;
  logic [PosW-1:0] scaled_col_q, scaled_col_d;

  logic accept, cfg_hit;
  logic last_rep_col, last_src_col, last_rep_row, col_wrap, load_last_col;
  logic [RowW-1:0] top_row;
  logic [RowW-1:0] restart_row;

  // Effective register values
  assign sx = clamp_scale(scale_x_q);
  assign sy = clamp_scale(scale_y_q);
  assign w  = clamp_size(width_q, SizeW'(MaxWidth));
  assign h  = clamp_size(height_q, SizeW'(MaxHeight));
  assign top_row = RowW'(h - SizeW'(1));

  // A height write restarts reading from the top row of the new height
  assign restart_row = (cfg_idx_i == RegFrameHeight)
                     ? RowW'(clamp_size(cfg_data_i, SizeW'(MaxHeight)) - SizeW'(1))
                     : top_row;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == RegScaleX || cfg_idx_i == RegScaleY ||
                                cfg_idx_i == RegFrameWidth || cfg_idx_i == RegFrameHeight);

  // Position of the current output pixel within the scaled frame
  assign last_rep_col  = ({1'b0, rep_col_q} + ScaleW'(1)) >= sx;
  assign last_src_col  = ({1'b0, src_col_q} + SizeW'(1)) >= w;
  assign last_rep_row  = ({1'b0, rep_row_q} + ScaleW'(1)) >= sy;
  assign col_wrap      = last_rep_col && last_src_col;
  assign load_last_col = ({1'b0, load_col_q} + SizeW'(1)) >= w;

  // Build the command for this transaction
  always_comb begin
    cmd_o.is_load   = (mode_i == ModeLoad);
    cmd_o.addr      = (mode_i == ModeLoad) ? {load_row_q, load_col_q}
                                           : {src_row_q, src_col_q};
    cmd_o.pix       = pix_i;
    cmd_o.row       = scaled_row_q;
    cmd_o.col       = scaled_col_q;
    cmd_o.frame_end = col_wrap && last_rep_row && (src_row_q == '0);
  end

  // Advance load and read positions
  always_comb begin
    load_row_d   = load_row_q;
    load_col_d   = load_col_q;
    src_row_d    = src_row_q;
    src_col_d    = src_col_q;
    rep_row_d    = rep_row_q;
    rep_col_d    = rep_col_q;
    scaled_row_d = scaled_row_q;
    scaled_col_d = scaled_col_q;
    if (cfg_hit) begin
      load_row_d   = '0;
      load_col_d   = '0;
      src_row_d    = restart_row;
      src_col_d    = '0;
      rep_row_d    = '0;
      rep_col_d    = '0;
      scaled_row_d = '0;
      scaled_col_d = '0;
    end else if (accept && mode_i == ModeLoad) begin
      if (load_last_col) begin
        load_col_d = '0;
        if (({1'b0, load_row_q} + SizeW'(1)) >= h) load_row_d = '0;
        else load_row_d = load_row_q + RowW'(1);
      end else begin
        load_col_d = load_col_q + ColW'(1);
      end
    end else if (accept) begin
      if (last_rep_col) begin
        rep_col_d = '0;
        src_col_d = last_src_col ? '0 : src_col_q + ColW'(1);
      end else begin
        rep_col_d = rep_col_q + RepW'(1);
      end
      if (col_wrap) begin
        scaled_col_d = '0;
        scaled_row_d = scaled_row_q + PosW'(1);
        if (last_rep_row) begin
          rep_row_d = '0;
          if (src_row_q == '0) begin
            src_row_d    = top_row;
            scaled_row_d = '0;
          end else begin
            src_row_d = src_row_q - RowW'(1);
          end
        end else begin
          rep_row_d = rep_row_q + RepW'(1);
        end
      end else begin
        scaled_col_d = scaled_col_q + PosW'(1);
      end
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= ScaleW'(1);
      scale_y_q <= ScaleW'(1);
      width_q   <= SizeW'(MaxWidth);
      height_q  <= SizeW'(MaxHeight);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScaleX:      scale_x_q <= cfg_data_i[ScaleW-1:0];
        RegScaleY:      scale_y_q <= cfg_data_i[ScaleW-1:0];
        RegFrameWidth:  width_q   <= cfg_data_i;
        RegFrameHeight: height_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q   <= '0;
      load_col_q   <= '0;
      src_row_q    <= RowW'(MaxHeight - 1);
      src_col_q    <= '0;
      rep_row_q    <= '0;
      rep_col_q    <= '0;
      scaled_row_q <= '0;
      scaled_col_q <= '0;
    end else begin
      load_row_q   <= load_row_d;
      load_col_q   <= load_col_d;
      src_row_q    <= src_row_d;
      src_col_q    <= src_col_d;
      rep_row_q    <= rep_row_d;
      rep_col_q    <= rep_col_d;
      scaled_row_q <= scaled_row_d;
      scaled_col_q <= scaled_col_d;
    end
  end

endmodule

/* rtl/ipu_fifo.sv */
// Short command queue between the front and the back part.
// Uses ipu_pkg for the command type and depth.
module ipu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ipu_pkg::ipu_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output ipu_pkg::ipu_cmd_t rdata_o,
  output logic              empty_o
);
  import ipu_pkg::*;

  ipu_cmd_t          slots_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QPtrW:0]    count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= wdata_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QPtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QPtrW+1)'(1);
        2'b01:   count_q <= count_q - (QPtrW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/ipu_back.sv */
// Back part: frame store memory and the output register.
// Takes commands from the queue; uses ipu_pkg.
module ipu_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  ipu_pkg::ipu_cmd_t         cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ipu_pkg::PixW-1:0]  out_pix_o,
  output logic [ipu_pkg::PosW-1:0]  out_row_o,
  output logic [ipu_pkg::PosW-1:0]  out_col_o,
  output logic                      out_frame_end_o
);
  import ipu_pkg::*;

  logic [PixW-1:0] store_q [MaxWidth*MaxHeight];
  logic [PixW-1:0] rdata_q;
  logic [PosW-1:0] row_q, col_q;
  logic            frame_end_q;
  logic            valid_q;
  logic            slot_free, do_write, do_read;

  // A load needs no output slot; a fetch waits for one
  assign slot_free = !valid_q || out_ready_i;
  assign pop_o     = !empty_i && (cmd_i.is_load || slot_free);
  assign do_write  = pop_o && cmd_i.is_load;
  assign do_read   = pop_o && !cmd_i.is_load;

  // Frame store: one write or one read per cycle, read data registered
  always_ff @(posedge clk_i) begin
    if (do_write) store_q[cmd_i.addr] <= cmd_i.pix;
    if (do_read)  rdata_q <= store_q[cmd_i.addr];
  end

  // Capture output pixel position alongside the read
  always_ff @(posedge clk_i) begin
    if (do_read) begin
      row_q       <= cmd_i.row;
      col_q       <= cmd_i.col;
      frame_end_q <= cmd_i.frame_end;
    end
  end

  // Output valid: set on a fetch, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (do_read) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_pix_o       = rdata_q;
  assign out_row_o       = row_q;
  assign out_col_o       = col_q;
  assign out_frame_end_o = frame_end_q;

endmodule

/* tb/integer_pixel_upscaler_vflip_tb.sv */
// Testbench of the integer pixel upscaler with vertical flip: loads frames, fetches the
// scaled image and checks every output pixel against a local predictor of the block.
// Depends on ipu_pkg, ipu_in_if/ipu_out_if and integer_pixel_upscaler_vflip.
module integer_pixel_upscaler_vflip_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipu_pkg::*;

  localparam int StallLimit     = 2000;
  localparam int SettleCycles   = 8;
  localparam int IdlePct        = 16;
  localparam int FirstUnusedReg = 4;
  localparam int RandomItems    = 300;
  localparam int MaxPrints      = 40;
  localparam int FetchCap       = 160;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [PosW-1:0]  row;
    logic [PosW-1:0]  col;
    logic             frame_end;
  } scaled_pixel_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  ipu_in_if  in_ch();
  ipu_out_if out_ch();

  integer_pixel_upscaler_vflip dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predictor state: configuration, positions and the frame store
  logic [ScaleW-1:0] scale_x_q, scale_y_q;
  logic [SizeW-1:0]  width_q, height_q;
  logic [RowW-1:0]   load_row_q;
  logic [ColW-1:0]   load_col_q;
  logic [RowW-1:0]   src_row_q;
  logic [RepW-1:0]   rep_row_q;
  logic [ColW-1:0]   src_col_q;
  logic [RepW-1:0]   rep_col_q;
  logic [PosW-1:0]   out_row_q, out_col_q;
  logic [PixW-1:0]   image_mem [MaxWidth*MaxHeight];
  bit                loaded    [MaxWidth*MaxHeight];

  scaled_pixel_t pending_pixels[$];
  scaled_pixel_t want_pix;
  int            err_count;
  int            items_sent;
  int            stall_cycles;
  bit            steady;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Zero maps to one, anything above the maximum is clipped
  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clip(width_q, MaxWidth);
  endfunction

  function automatic int unsigned eff_height();
    return clip(height_q, MaxHeight);
  endfunction

  function automatic int unsigned eff_scale_x();
    return clip(scale_x_q, MaxScale);
  endfunction

  function automatic int unsigned eff_scale_y();
    return clip(scale_y_q, MaxScale);
  endfunction

  function automatic void restart_positions();
    load_row_q = '0;
    load_col_q = '0;
    src_row_q  = RowW'(eff_height() - 1);
    rep_row_q  = '0;
    src_col_q  = '0;
    rep_col_q  = '0;
    out_row_q  = '0;
    out_col_q  = '0;
  endfunction

  function automatic void reset_predictor();
    scale_x_q = ScaleW'(1);
    scale_y_q = ScaleW'(1);
    width_q   = SizeW'(MaxWidth);
    height_q  = SizeW'(MaxHeight);
    restart_positions();
  endfunction

  // Known registers take their low bits and restart positions; others are dropped
  function automatic void predict_reg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    case (idx)
      RegScaleX:      scale_x_q = data[ScaleW-1:0];
      RegScaleY:      scale_y_q = data[ScaleW-1:0];
      RegFrameWidth:  width_q   = data[SizeW-1:0];
      RegFrameHeight: height_q  = data[SizeW-1:0];
      default:        return;
    endcase
    restart_positions();
  endfunction

  // Store one pixel and advance the raster load position
  function automatic void predict_load(logic [PixW-1:0] pix);
    int unsigned row, col, addr;
    row  = load_row_q;
    col  = load_col_q;
    addr = row * MaxWidth + col;
    image_mem[addr] = pix;
    loaded[addr]    = 1'b1;
    col++;
    if (col >= eff_width()) begin
      col = 0;
      row++;
      if (row >= eff_height()) row = 0;
    end
    load_row_q = RowW'(row);
    load_col_q = ColW'(col);
  endfunction

  // True when the entry the next fetch reads has been loaded
  function automatic bit fetch_ready();
    return loaded[int'(src_row_q) * MaxWidth + int'(src_col_q)];
  endfunction

  // Produce the next scaled pixel and advance the flipped read position
  function automatic scaled_pixel_t predict_fetch();
    int unsigned w, h, sx, sy;
    int unsigned rcol, scol, rrow, srow, orow, ocol;
    logic [PixW-1:0] pix;
    scaled_pixel_t res;
    w    = eff_width();
    h    = eff_height();
    sx   = eff_scale_x();
    sy   = eff_scale_y();
    rcol = rep_col_q;
    scol = src_col_q;
    rrow = rep_row_q;
    srow = src_row_q;
    orow = out_row_q;
    ocol = out_col_q;
    pix  = image_mem[srow * MaxWidth + scol];
    res.red       = pix[PixW-1 -: ChanW];
    res.green     = pix[2*ChanW-1 -: ChanW];
    res.blue      = pix[ChanW-1:0];
    res.row       = PosW'(orow);
    res.col       = PosW'(ocol);
    res.frame_end = (rcol + 1 >= sx) && (scol + 1 >= w) && (rrow + 1 >= sy) && (srow == 0);
    rcol++;
    if (rcol >= sx) begin
      rcol = 0;
      scol++;
    end
    if (scol >= w) begin
      scol = 0;
      ocol = 0;
      rrow++;
      orow++;
      if (rrow >= sy) begin
        rrow = 0;
        if (srow == 0) begin
          srow = h - 1;
          orow = 0;
        end else begin
          srow--;
        end
      end
    end else begin
      ocol++;
    end
    rep_col_q = RepW'(rcol);
    src_col_q = ColW'(scol);
    rep_row_q = RepW'(rrow);
    src_row_q = RowW'(srow);
    out_row_q = PosW'(orow);
    out_col_q = PosW'(ocol);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= MaxPrints)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [PosW-1:0] want, logic [PosW-1:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  // Compare each output transaction with the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", 0, 0);
      end else begin
        want_pix = pending_pixels.pop_front();
        check_field("out_red",   want_pix.red,       out_ch.out_red);
        check_field("out_green", want_pix.green,     out_ch.out_green);
        check_field("out_blue",  want_pix.blue,      out_ch.out_blue);
        check_field("out_row",   want_pix.row,       out_ch.out_row);
        check_field("out_col",   want_pix.col,       out_ch.out_col);
        check_field("frame_end", want_pix.frame_end, out_ch.frame_end);
      end
    end
  end

  // Stall the receiver at random, except during a steady stretch
  always @(negedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("integer_pixel_upscaler_vflip_tb: FAIL");
      $finish;
    end
  end

  // Send one input transaction, with random idle cycles before it
  task automatic send_item(logic mode, logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                           logic [ChanW-1:0] b);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.in_red   <= r;
    in_ch.in_green <= g;
    in_ch.in_blue  <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (mode == ModeFetch) pending_pixels.push_back(predict_fetch());
    else predict_load({r, g, b});
    items_sent++;
  endtask

  task automatic load_random_pixel();
    send_item(ModeLoad, ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
  endtask

  // Fetch colors are ignored by the block, so drive noise on them
  task automatic fetch_pixels(int unsigned n);
    repeat (n) send_item(ModeFetch, ChanW'($urandom), ChanW'($urandom), ChanW'($urandom));
  endtask

  task automatic load_frame();
    repeat (eff_width() * eff_height()) load_random_pixel();
  endtask

  // Hold the sender until every expected pixel has come out
  task automatic hold_until_empty();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  // Drain the block, then let trailing loads finish before a register write
  task automatic settle_block();
    hold_until_empty();
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    predict_reg_write(idx, data);
  endtask

  task automatic write_unused_reg();
    write_reg(CfgIdxW'($urandom_range(FirstUnusedReg, (1 << CfgIdxW) - 1)), CfgW'($urandom));
  endtask

  task automatic set_geometry(int unsigned sx, int unsigned sy, int unsigned w,
                              int unsigned h);
    write_reg(RegScaleX, CfgW'(sx));
    write_reg(RegScaleY, CfgW'(sy));
    write_reg(RegFrameWidth, CfgW'(w));
    write_reg(RegFrameHeight, CfgW'(h));
  endtask

  // Reset width and scales stay; only the height is made small; run without idling
  task automatic test_default_geometry();
    settle_block();
    steady = 1'b1;
    write_reg(RegFrameHeight, CfgW'(1));
    load_frame();
    fetch_pixels(eff_width() + 2);
    steady = 1'b0;
  endtask

  // Color extremes, flip order, frame end, read wrap and load wrap on a 2x2 frame
  task automatic test_directed_pixels();
    settle_block();
    set_geometry(1, 1, 2, 2);
    send_item(ModeLoad, 8'h00, 8'h00, 8'h00);
    send_item(ModeLoad, 8'hFF, 8'hFF, 8'hFF);
    send_item(ModeLoad, 8'hFF, 8'h00, 8'h55);
    send_item(ModeLoad, 8'h00, 8'hAA, 8'hFF);
    fetch_pixels(5);
    send_item(ModeLoad, 8'hAA, 8'h55, 8'h0F);
    send_item(ModeLoad, 8'h55, 8'hAA, 8'hF0);
    send_item(ModeLoad, 8'h01, 8'h80, 8'h7F);
    send_item(ModeLoad, 8'hFE, 8'h7F, 8'h80);
    fetch_pixels(3);
  endtask

  // A known register restarts both positions; an unknown index changes nothing
  task automatic test_register_restart();
    settle_block();
    write_unused_reg();
    fetch_pixels(2);
    load_random_pixel();
    settle_block();
    write_reg(RegScaleX, CfgW'(2));
    load_random_pixel();
    fetch_pixels(6);
    settle_block();
    write_unused_reg();
    fetch_pixels(3);
  endtask

  // Scales of zero and above the maximum, sizes of zero
  task automatic test_scale_clamp();
    settle_block();
    set_geometry(0, 31, 0, 0);
    load_frame();
    fetch_pixels(18);
    settle_block();
    set_geometry(17, 2, 1, 2);
    load_frame();
    fetch_pixels(66);
  endtask

  // Width above the maximum clips to the full row; row 0 was loaded in full by the first test
  task automatic test_size_extremes();
    settle_block();
    set_geometry(1, 1, 511, 1);
    fetch_pixels(eff_width() * eff_scale_x() + 2);
  endtask

  // Random geometries: mostly full loads then fetches, with stray loads and partial frames
  task automatic test_random_frames();
    int unsigned kind, frame_no, n_fetch, frame_px, done, start;
    int unsigned sx, sy, w, h;
    frame_no = 0;
    start    = items_sent;
    while (items_sent < start + RandomItems) begin
      settle_block();
      steady = (frame_no == 1);
      kind   = $urandom_range(19);
      if (kind == 0) begin
        w  = $urandom_range(200, 511);
        h  = 1;
        sx = $urandom_range(1, 2);
        sy = 1;
      end else if (kind == 1) begin
        w  = 1;
        h  = $urandom_range(100, 300);
        sx = 1;
        sy = $urandom_range(1, 2);
      end else if (kind <= 4) begin
        w  = $urandom_range(0, 2);
        h  = $urandom_range(0, 2);
        sx = $urandom_range(8, 31);
        sy = $urandom_range(8, 31);
      end else begin
        w  = $urandom_range(1, 8);
        h  = $urandom_range(1, 8);
        sx = $urandom_range(0, 4);
        sy = $urandom_range(0, 4);
      end
      // Scale registers ignore the upper data bits
      if ($urandom_range(3) == 0) sx = sx | ($urandom_range(15) << ScaleW);
      if ($urandom_range(3) == 0) sy = sy | ($urandom_range(15) << ScaleW);
      if ($urandom_range(4) != 0) write_reg(RegScaleX, CfgW'(sx));
      if ($urandom_range(4) != 0) write_reg(RegScaleY, CfgW'(sy));
      if ($urandom_range(4) != 0) write_reg(RegFrameWidth, CfgW'(w));
      if ($urandom_range(4) != 0) write_reg(RegFrameHeight, CfgW'(h));
      if ($urandom_range(6) == 0) write_unused_reg();
      if ($urandom_range(5) != 0) load_frame();
      frame_px = eff_width() * eff_height() * eff_scale_x() * eff_scale_y();
      n_fetch  = frame_px + $urandom_range(frame_px / 2 + 2);
      if (n_fetch > FetchCap) n_fetch = FetchCap;
      done = 0;
      while (done < n_fetch) begin
        // Load at random, and always when the next read would hit an entry not yet written
        if ($urandom_range(99) < 15 || !fetch_ready()) begin
          load_random_pixel();
        end else begin
          fetch_pixels(1);
          done++;
        end
        if ($urandom_range(199) == 0) hold_until_empty();
      end
      steady = 1'b0;
      frame_no++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.mode     = ModeLoad;
    in_ch.in_red   = '0;
    in_ch.in_green = '0;
    in_ch.in_blue  = '0;
    out_ch.ready   = 1'b0;
    err_count      = 0;
    items_sent     = 0;
    stall_cycles   = 0;
    steady         = 1'b0;
    reset_predictor();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_geometry();
    test_directed_pixels();
    test_register_restart();
    test_scale_clamp();
    test_size_extremes();
    test_random_frames();

    settle_block();
    if (err_count == 0 && pending_pixels.size() == 0) begin
      $display("integer_pixel_upscaler_vflip_tb: PASS");
    end else begin
      $display("integer_pixel_upscaler_vflip_tb: FAIL");
    end
    $finish;
  end

endmodule
